// ----- sv/multi_motor_power_estimate_limit_macros.svh -----
// Assertion helpers for the motor power estimate and limit block.
`ifndef MULTI_MOTOR_POWER_ESTIMATE_LIMIT_MACROS_SVH
`define MULTI_MOTOR_POWER_ESTIMATE_LIMIT_MACROS_SVH
`ifndef SYNTH
`define MPEL_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("power limit assertion failed");
`define MPEL_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("power limit forbidden condition seen");
`else
`define MPEL_ASSERT(label, clk, rst_n, prop)
`define MPEL_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- sv/mpel_pkg.sv -----
package mpel_pkg;

	localparam int MAX_MOTORS_DEF  = 4;
	localparam int DRIVE_WIDTH_DEF = 16;

	localparam int COEF_W        = 32;
	localparam int COEF_FRAC_W   = 32;
	localparam int DRV_SQ_FRAC_W = 16;
	localparam int LIMIT_W       = 17;
	localparam int STATIC_W      = 17;
	localparam int RPM_W         = 15;
	localparam int COUNT_W       = 3;
	localparam int TOTAL_W       = 25;
	localparam int STATUS_W      = 2;
	localparam int RATIO_W       = 16;
	localparam int LANE_PWR_W    = 29;
	localparam int LANE_LAT      = 3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_TORQUE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SQ = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SQ = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_STATIC   = CFG_IDX_W'(3);

	localparam logic [STATUS_W-1:0] ST_WITHIN  = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_SCALED  = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_SKIPPED = STATUS_W'(2);

	typedef struct packed {
		logic signed [COEF_W-1:0] torque;
		logic signed [COEF_W-1:0] speed_sq;
		logic signed [COEF_W-1:0] drive_sq;
	} mpel_coef_t;

	typedef struct packed {
		logic [TOTAL_W-1:0]  total;
		logic [STATUS_W-1:0] status;
	} mpel_res_t;

	// Width of the full precision total: lane estimates plus static power.
	function automatic int sum_width(input int max_motors);
		return LANE_PWR_W + $clog2(max_motors + 1);
	endfunction

endpackage

// ----- sv/mpel_cmd_if.sv -----
interface mpel_cmd_if #(
	parameter int MAX_MOTORS  = mpel_pkg::MAX_MOTORS_DEF,
	parameter int DRIVE_WIDTH = mpel_pkg::DRIVE_WIDTH_DEF
);
	import mpel_pkg::*;

	logic                                    valid;
	logic                                    ready;
	logic signed [LIMIT_W-1:0]               pwr_budget;
	logic [COUNT_W-1:0]                      motor_count;
	logic [MAX_MOTORS-1:0][DRIVE_WIDTH-1:0]  drive;
	logic [MAX_MOTORS-1:0][RPM_W-1:0]        rpm;

	modport source (output valid, pwr_budget, motor_count, drive, rpm, input ready);
	modport sink (input valid, pwr_budget, motor_count, drive, rpm, output ready);

endinterface

// ----- sv/mpel_res_if.sv -----
interface mpel_res_if #(
	parameter int MAX_MOTORS  = mpel_pkg::MAX_MOTORS_DEF,
	parameter int DRIVE_WIDTH = mpel_pkg::DRIVE_WIDTH_DEF
);
	import mpel_pkg::*;

	logic                                    valid;
	logic                                    ready;
	logic [MAX_MOTORS-1:0][DRIVE_WIDTH-1:0]  limited;
	logic signed [TOTAL_W-1:0]               total_power;
	logic [STATUS_W-1:0]                     status;

	modport source (output valid, limited, total_power, status, input ready);
	modport sink (input valid, limited, total_power, status, output ready);

endinterface

// ----- sv/mpel_lane.sv -----
module mpel_lane #(
	parameter int DRIVE_WIDTH = mpel_pkg::DRIVE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [DRIVE_WIDTH-1:0]        drive,
	input  logic signed [mpel_pkg::RPM_W-1:0]    rpm,
	input  mpel_pkg::mpel_coef_t                 coef,
	output logic signed [mpel_pkg::LANE_PWR_W-1:0] pwr_s3
);
	import mpel_pkg::*;

	localparam int PTQ_W = DRIVE_WIDTH + RPM_W;
	localparam int PSP_W = 2 * RPM_W;
	localparam int PDR_W = 2 * DRIVE_WIDTH;
	localparam int MTQ_W = COEF_W + PTQ_W + 1;
	localparam int MSP_W = COEF_W + PSP_W + 1;
	localparam int MDR_W = COEF_W + PDR_W + 1;
	localparam int TQ_SH = COEF_FRAC_W + DRIVE_WIDTH - 1;
	localparam int SP_SH = COEF_FRAC_W;
	localparam int DR_SH = DRV_SQ_FRAC_W + 2 * (DRIVE_WIDTH - 1);

	logic [DRIVE_WIDTH-1:0]   ad;
	logic [RPM_W-1:0]         ar;
	logic [PTQ_W-1:0]         p_tq_s1;
	logic [PSP_W-1:0]         p_sp_s1;
	logic [PDR_W-1:0]         p_dr_s1;
	logic signed [MTQ_W-1:0]  m_tq_s2;
	logic signed [MSP_W-1:0]  m_sp_s2;
	logic signed [MDR_W-1:0]  m_dr_s2;
	logic signed [MTQ_W-1:0]  sh_tq;
	logic signed [MSP_W-1:0]  sh_sp;
	logic signed [MDR_W-1:0]  sh_dr;

	assign ad = drive[DRIVE_WIDTH-1] ? $unsigned(-drive) : $unsigned(drive);
	assign ar = rpm[RPM_W-1] ? $unsigned(-rpm) : $unsigned(rpm);

	always_ff @(posedge clk) begin
		if (en) begin
			p_tq_s1 <= ad * ar;
			p_sp_s1 <= ar * ar;
			p_dr_s1 <= ad * ad;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tq_s2 <= coef.torque * $signed({1'b0, p_tq_s1});
			m_sp_s2 <= coef.speed_sq * $signed({1'b0, p_sp_s1});
			m_dr_s2 <= coef.drive_sq * $signed({1'b0, p_dr_s1});
		end
	end

	// Arithmetic shifts give the floor of each scaled term.
	assign sh_tq = m_tq_s2 >>> TQ_SH;
	assign sh_sp = m_sp_s2 >>> SP_SH;
	assign sh_dr = m_dr_s2 >>> DR_SH;

	always_ff @(posedge clk) begin
		if (en) begin
			pwr_s3 <= $signed(sh_tq[LANE_PWR_W-1:0]) + $signed(sh_sp[LANE_PWR_W-1:0])
				+ $signed(sh_dr[LANE_PWR_W-1:0]);
		end
	end

endmodule

// ----- sv/mpel_merge.sv -----
module mpel_merge #(
	parameter int MAX_MOTORS = mpel_pkg::MAX_MOTORS_DEF
) (
	input  logic                                      clk,
	input  logic                                      en,
	input  logic signed [mpel_pkg::LIMIT_W-1:0]       limit,
	input  logic [MAX_MOTORS-1:0]                     act_mask,
	input  logic signed [mpel_pkg::LANE_PWR_W-1:0]    lane_pwr [MAX_MOTORS],
	input  logic signed [mpel_pkg::STATIC_W-1:0]      static_power,
	output mpel_pkg::mpel_res_t                       res_s4,
	output logic [mpel_pkg::LIMIT_W-2:0]              num_s4,
	output logic [mpel_pkg::sum_width(MAX_MOTORS)-2:0] den_s4
);
	import mpel_pkg::*;

	localparam int SUM_W = sum_width(MAX_MOTORS);
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (TOTAL_W - 1) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] lim_ext;
	logic [TOTAL_W-1:0]      total_sat;
	mpel_res_t               res_nx;

	always_comb begin
		sum = SUM_W'(static_power);
		for (int i = 0; i < MAX_MOTORS; i++) begin
			if (act_mask[i]) begin
				sum = sum + SUM_W'(lane_pwr[i]);
			end
		end
	end

	assign lim_ext = SUM_W'(limit);

	always_comb begin
		if (sum > SAT_HI) begin
			total_sat = SAT_HI[TOTAL_W-1:0];
		end else if (sum < SAT_LO) begin
			total_sat = SAT_LO[TOTAL_W-1:0];
		end else begin
			total_sat = sum[TOTAL_W-1:0];
		end
	end

	always_comb begin
		if (limit[LIMIT_W-1]) begin
			res_nx.status = ST_SKIPPED;
			res_nx.total  = '0;
		end else if (sum > lim_ext) begin
			res_nx.status = ST_SCALED;
			res_nx.total  = total_sat;
		end else begin
			res_nx.status = ST_WITHIN;
			res_nx.total  = total_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= res_nx;
			num_s4 <= limit[LIMIT_W-2:0];
			den_s4 <= sum[SUM_W-2:0];
		end
	end

endmodule

// ----- sv/mpel_div.sv -----
module mpel_div #(
	parameter int NUM_W = mpel_pkg::LIMIT_W - 1,
	parameter int DEN_W = mpel_pkg::sum_width(mpel_pkg::MAX_MOTORS_DEF) - 1,
	parameter int QUO_W = mpel_pkg::RATIO_W,
	parameter int PAY_W = 8
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [PAY_W-1:0] pay_in,
	output logic [QUO_W-1:0] quo,
	output logic [PAY_W-1:0] pay_out
);
	import mpel_pkg::*;

	logic [DEN_W-1:0] rem_q [QUO_W];
	logic [DEN_W-1:0] den_q [QUO_W];
	logic [QUO_W-1:0] quo_q [QUO_W];
	logic [PAY_W-1:0] pay_q [QUO_W];
	logic [DEN_W-1:0] rem_nx [QUO_W];
	logic [QUO_W-1:0] quo_nx [QUO_W];

	// One quotient bit per stage; the remainder starts as the numerator,
	// which is below the divisor whenever the quotient is used.
	always_comb begin
		logic [DEN_W-1:0] rp;
		logic [DEN_W-1:0] dp;
		logic [QUO_W-1:0] qp;
		logic [DEN_W+1:0] trial;
		for (int k = 0; k < QUO_W; k++) begin
			if (k == 0) begin
				rp = DEN_W'(num);
				dp = den;
				qp = '0;
			end else begin
				rp = rem_q[k-1];
				dp = den_q[k-1];
				qp = quo_q[k-1];
			end
			trial = {1'b0, rp, 1'b0} - {2'b00, dp};
			if (!trial[DEN_W+1]) begin
				rem_nx[k] = trial[DEN_W-1:0];
				quo_nx[k] = {qp[QUO_W-2:0], 1'b1};
			end else begin
				rem_nx[k] = {rp[DEN_W-2:0], 1'b0};
				quo_nx[k] = {qp[QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QUO_W; k++) begin
				rem_q[k] <= rem_nx[k];
				quo_q[k] <= quo_nx[k];
				if (k == 0) begin
					den_q[k] <= den;
					pay_q[k] <= pay_in;
				end else begin
					den_q[k] <= den_q[k-1];
					pay_q[k] <= pay_q[k-1];
				end
			end
		end
	end

	assign quo     = quo_q[QUO_W-1];
	assign pay_out = pay_q[QUO_W-1];

endmodule

// ----- sv/multi_motor_power_estimate_limit.sv -----
// Channel  Dir  Handshake        Payload
// cmd      in   valid / ready    pwr_budget, motor_count, drive[], rpm[]
// res      out  valid / ready    limited[], total_power, status
// cfg      in   cfg_wr_en        cfg_idx, cfg_wdata
//
// One transaction is accepted per cycle unless a stall on res holds cmd.ready low.
// The pipeline is three lane stages (two multiplies and a sum), one merge stage,
// 16 divider stages (one ratio bit each), one scaling multiply and the output register.
// Reset clears the configuration registers and the valid pipeline; cmd.ready is low in reset.
// A stall on res freezes the whole pipeline and holds cmd.ready low.
`include "multi_motor_power_estimate_limit_macros.svh"

module multi_motor_power_estimate_limit #(
	parameter int MAX_MOTORS  = mpel_pkg::MAX_MOTORS_DEF,
	parameter int DRIVE_WIDTH = mpel_pkg::DRIVE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [mpel_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [mpel_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	mpel_cmd_if.sink                           cmd,
	mpel_res_if.source                         res
);
	import mpel_pkg::*;

	localparam int SUM_W    = sum_width(MAX_MOTORS);
	localparam int DEN_W    = SUM_W - 1;
	localparam int NUM_W    = LIMIT_W - 1;
	localparam int RES_BITS = $bits(mpel_res_t);
	localparam int PAY_W    = MAX_MOTORS + MAX_MOTORS * DRIVE_WIDTH + RES_BITS;
	localparam int PROD_W   = DRIVE_WIDTH + RATIO_W;
	localparam int LAT      = LANE_LAT + 1 + RATIO_W + 2;

	typedef logic [MAX_MOTORS-1:0][DRIVE_WIDTH-1:0] drive_vec_t;

	mpel_coef_t                    coef_q;
	logic signed [STATIC_W-1:0]    static_q;
	logic [LAT-1:0]                vld_q;
	logic                          adv;

	logic [MAX_MOTORS-1:0]         act_in;
	logic signed [LIMIT_W-1:0]     limit_s1, limit_s2, limit_s3;
	logic [MAX_MOTORS-1:0]         act_s1, act_s2, act_s3, act_s4;
	drive_vec_t                    drive_s1, drive_s2, drive_s3, drive_s4;
	logic signed [LANE_PWR_W-1:0]  lane_pwr [MAX_MOTORS];

	mpel_res_t                     res_s4;
	logic [NUM_W-1:0]              num_s4;
	logic [DEN_W-1:0]              den_s4;
	logic [PAY_W-1:0]              pay_in;
	logic [PAY_W-1:0]              pay_out;
	logic [RATIO_W-1:0]            ratio_dv;
	logic [MAX_MOTORS-1:0]         act_dv;
	drive_vec_t                    drive_dv;
	mpel_res_t                     res_dv;
	logic [DRIVE_WIDTH-1:0]        ad_dv [MAX_MOTORS];

	logic [PROD_W-1:0]             prod_s21 [MAX_MOTORS];
	drive_vec_t                    drive_s21;
	logic [MAX_MOTORS-1:0]         act_s21;
	mpel_res_t                     res_s21;

	drive_vec_t                    limited_nx;
	drive_vec_t                    limited_q;
	logic [TOTAL_W-1:0]            total_q;
	logic [STATUS_W-1:0]           status_q;

	logic                          out_scaled;
	logic                          out_skipped;
	logic                          div_scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= '0;
			static_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				CFG_TORQUE:   coef_q.torque   <= $signed(cfg_wdata);
				CFG_SPEED_SQ: coef_q.speed_sq <= $signed(cfg_wdata);
				CFG_DRIVE_SQ: coef_q.drive_sq <= $signed(cfg_wdata);
				CFG_STATIC:   static_q        <= $signed(cfg_wdata[STATIC_W-1:0]);
				default: ;
			endcase
		end
	end

	assign adv       = !vld_q[LAT-1] || res.ready;
	assign cmd.ready = adv && arst_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], cmd.valid};
		end
	end

	// A lane count above the lane total simply enables every lane.
	always_comb begin
		for (int i = 0; i < MAX_MOTORS; i++) begin
			act_in[i] = int'(cmd.motor_count) > i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			limit_s1 <= cmd.pwr_budget;
			act_s1   <= act_in;
			drive_s1 <= cmd.drive;
			limit_s2 <= limit_s1;
			act_s2   <= act_s1;
			drive_s2 <= drive_s1;
			limit_s3 <= limit_s2;
			act_s3   <= act_s2;
			drive_s3 <= drive_s2;
			act_s4   <= act_s3;
			drive_s4 <= drive_s3;
		end
	end

	for (genvar i = 0; i < MAX_MOTORS; i++) begin : g_lane
		mpel_lane #(
			.DRIVE_WIDTH(DRIVE_WIDTH)
		) u_lane (
			.clk   (clk),
			.en    (adv),
			.drive ($signed(cmd.drive[i])),
			.rpm   ($signed(cmd.rpm[i])),
			.coef  (coef_q),
			.pwr_s3(lane_pwr[i])
		);
	end

	mpel_merge #(
		.MAX_MOTORS(MAX_MOTORS)
	) u_merge (
		.clk         (clk),
		.en          (adv),
		.limit       (limit_s3),
		.act_mask    (act_s3),
		.lane_pwr    (lane_pwr),
		.static_power(static_q),
		.res_s4      (res_s4),
		.num_s4      (num_s4),
		.den_s4      (den_s4)
	);

	assign pay_in = {act_s4, drive_s4, res_s4};

	mpel_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W),
		.QUO_W(RATIO_W),
		.PAY_W(PAY_W)
	) u_div (
		.clk    (clk),
		.en     (adv),
		.num    (num_s4),
		.den    (den_s4),
		.pay_in (pay_in),
		.quo    (ratio_dv),
		.pay_out(pay_out)
	);

	assign {act_dv, drive_dv, res_dv} = pay_out;

	always_comb begin
		for (int i = 0; i < MAX_MOTORS; i++) begin
			ad_dv[i] = drive_dv[i][DRIVE_WIDTH-1] ? -drive_dv[i] : drive_dv[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < MAX_MOTORS; i++) begin
				prod_s21[i] <= ad_dv[i] * ratio_dv;
			end
			drive_s21 <= drive_dv;
			act_s21   <= act_dv;
			res_s21   <= res_dv;
		end
	end

	always_comb begin
		logic [DRIVE_WIDTH-1:0] mag;
		for (int i = 0; i < MAX_MOTORS; i++) begin
			mag = prod_s21[i][PROD_W-1:RATIO_W];
			if (res_s21.status == ST_SCALED && act_s21[i]) begin
				limited_nx[i] = drive_s21[i][DRIVE_WIDTH-1] ? -mag : mag;
			end else begin
				limited_nx[i] = drive_s21[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			limited_q <= limited_nx;
			total_q   <= res_s21.total;
			status_q  <= res_s21.status;
		end
	end

	assign res.valid       = vld_q[LAT-1];
	assign res.limited     = limited_q;
	assign res.total_power = $signed(total_q);
	assign res.status      = status_q;

	assign out_scaled  = res.valid && res.status == ST_SCALED;
	assign out_skipped = res.valid && res.status == ST_SKIPPED;
	assign div_scaled  = vld_q[LANE_LAT] && res_s4.status == ST_SCALED;

	`MPEL_ASSERT(a_scaled_total_positive, clk, arst_n, out_scaled |-> res.total_power > 0)
	`MPEL_ASSERT_NEVER(a_skip_zero_total, clk, arst_n, out_skipped && res.total_power != '0)
	`MPEL_ASSERT(a_div_operands, clk, arst_n, div_scaled |-> den_s4 > DEN_W'(num_s4))

endmodule
